[hw/rtl/tile_gid_atlas_texcoord_top_defines.svh]
// ----------------------------------------------------------------------------
// Tile gid to atlas texcoord: assertion macros
// Shared check macros, sampled on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TILE_GID_ATLAS_TEXCOORD_TOP_DEFINES_SVH
`define TILE_GID_ATLAS_TEXCOORD_TOP_DEFINES_SVH

// same-cycle implication
`define TGAT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TGAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tgat_pkg.sv]
// ----------------------------------------------------------------------------
// Tile gid to atlas texcoord: package
// Field widths, tileset word layout, register indexes and pipeline types.
// ----------------------------------------------------------------------------
package tgat_pkg;

  localparam int NUM_SETS   = 4;
  localparam int SET_IDX_W  = 2;
  localparam int RAW_W      = 32;
  localparam int GID_W      = 29;
  localparam int FG_W       = 20;
  localparam int COLS_W     = 10;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 62;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int COORD_W    = 40;

  // flip flags in the raw gid
  localparam int HFLIP_BIT  = 31;
  localparam int VFLIP_BIT  = 30;
  localparam int DFLIP_BIT  = 29;

  // tileset word layout
  localparam int FG_LSB     = 0;
  localparam int COLS_LSB   = 20;
  localparam int TW_LSB     = 30;
  localparam int TH_LSB     = 38;
  localparam int MG_LSB     = 46;
  localparam int SP_LSB     = 54;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SET_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_WORD_0 = 3'd1;

  // divider: dividend padded to DIV_W, DIV_STEPS quotient bits per stage
  localparam int DIV_W      = 32;
  localparam int DIV_STEPS  = 8;
  localparam int DIV_STAGES = DIV_W / DIV_STEPS;

  localparam int PU_W       = COLS_W + BYTE_W + 1;
  localparam int PV_W       = GID_W + BYTE_W + 1;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic                 hit;
    logic [SET_IDX_W-1:0] set_index;
    logic [GID_W-1:0]     local_id;
    logic                 hf;
    logic                 vf;
    logic                 df;
    logic [COLS_W-1:0]    cols;
    logic [BYTE_W-1:0]    tw;
    logic [BYTE_W-1:0]    th;
    logic [BYTE_W-1:0]    mg;
    logic [BYTE_W-1:0]    sp;
    logic [COLS_W-1:0]    rem;
    logic [DIV_W-1:0]     dq;   // dividend bits shift out, quotient bits shift in
  } div_item_t;

  typedef struct packed {
    logic                 hit;
    logic [SET_IDX_W-1:0] set_index;
    logic [GID_W-1:0]     local_id;
    logic                 hf;
    logic                 vf;
    logic                 df;
    logic [BYTE_W-1:0]    tw;
    logic [BYTE_W-1:0]    th;
    logic [BYTE_W-1:0]    mg;
    logic [PU_W-1:0]      pu;
    logic [PV_W-1:0]      pv;
  } mul_item_t;

  typedef struct packed {
    coord_t [3:0] u;
    coord_t [3:0] v;
  } corners_t;

endpackage

[hw/rtl/tgat_in_if.sv]
// ----------------------------------------------------------------------------
// Tile gid to atlas texcoord: input channel
// Valid/ready channel carrying one raw tile gid per item.
// ----------------------------------------------------------------------------
interface tgat_in_if;
  import tgat_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_gid;

  modport source (output valid, output raw_gid, input ready);
  modport sink   (input valid, input raw_gid, output ready);
endinterface

[hw/rtl/tgat_out_if.sv]
// ----------------------------------------------------------------------------
// Tile gid to atlas texcoord: output channel
// Valid/ready channel carrying one lookup result per item.
// ----------------------------------------------------------------------------
interface tgat_out_if;
  import tgat_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [SET_IDX_W-1:0] set_index;
  logic [GID_W-1:0]     local_id;
  logic [COORD_W-1:0]   corner0_u;
  logic [COORD_W-1:0]   corner0_v;
  logic [COORD_W-1:0]   corner1_u;
  logic [COORD_W-1:0]   corner1_v;
  logic [COORD_W-1:0]   corner2_u;
  logic [COORD_W-1:0]   corner2_v;
  logic [COORD_W-1:0]   corner3_u;
  logic [COORD_W-1:0]   corner3_v;

  modport source (
    output valid, output hit, output set_index, output local_id,
    output corner0_u, output corner0_v, output corner1_u, output corner1_v,
    output corner2_u, output corner2_v, output corner3_u, output corner3_v,
    input ready
  );
  modport sink (
    input valid, input hit, input set_index, input local_id,
    input corner0_u, input corner0_v, input corner1_u, input corner1_v,
    input corner2_u, input corner2_v, input corner3_u, input corner3_v,
    output ready
  );
endinterface

[hw/rtl/tgat_div_stage.sv]
// ----------------------------------------------------------------------------
// Tile gid to atlas texcoord: divider stage
// One registered stage of the restoring divider, DIV_STEPS quotient bits.
// ----------------------------------------------------------------------------
module tgat_div_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  input  tgat_pkg::div_item_t up_item,
  input  logic                down_en,
  output logic                valid,
  output tgat_pkg::div_item_t item,
  output logic                en
);
  import tgat_pkg::*;

  div_item_t         item_next;
  logic [COLS_W:0]   trial;

  // rem < cols, so trial < 2*cols fits COLS_W+1 bits
  always_comb begin
    item_next = up_item;
    trial     = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial        = {item_next.rem, item_next.dq[DIV_W-1]};
      item_next.dq = {item_next.dq[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, item_next.cols}) begin
        item_next.rem   = COLS_W'(trial - {1'b0, item_next.cols});
        item_next.dq[0] = 1'b1;
      end else begin
        item_next.rem = trial[COLS_W-1:0];
      end
    end
  end

  assign en = !valid || down_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item <= item_next;
    end
  end

endmodule

[hw/rtl/tgat_corner.sv]
// ----------------------------------------------------------------------------
// Tile gid to atlas texcoord: corner builder
// Forms the tile rectangle from the products and permutes it by the flips.
// ----------------------------------------------------------------------------
module tgat_corner (
  input  tgat_pkg::mul_item_t m,
  output tgat_pkg::corners_t  c
);
  import tgat_pkg::*;

  coord_t   l, t, r, b;
  corners_t p;

  function automatic corners_t swap_c(corners_t x, logic [1:0] ia, logic [1:0] ib);
    corners_t y;
    y       = x;
    y.u[ia] = x.u[ib];
    y.u[ib] = x.u[ia];
    y.v[ia] = x.v[ib];
    y.v[ib] = x.v[ia];
    return y;
  endfunction

  always_comb begin
    l = COORD_W'(m.mg) + COORD_W'(m.pu);
    t = COORD_W'(m.mg) + COORD_W'(m.pv);
    r = COORD_W'(m.mg) + COORD_W'(m.tw) + COORD_W'(m.pu);
    b = COORD_W'(m.mg) + COORD_W'(m.th) + COORD_W'(m.pv);

    // left-top, right-top, right-bottom, left-bottom
    p.u[0] = l; p.v[0] = t;
    p.u[1] = r; p.v[1] = t;
    p.u[2] = r; p.v[2] = b;
    p.u[3] = l; p.v[3] = b;

    // flips apply in order h, v, d
    if (m.hf) begin
      p = swap_c(p, 2'd0, 2'd1);
      p = swap_c(p, 2'd3, 2'd2);
    end
    if (m.vf) begin
      p = swap_c(p, 2'd0, 2'd3);
      p = swap_c(p, 2'd1, 2'd2);
    end
    if (m.df) begin
      p = swap_c(p, 2'd1, 2'd3);
    end

    c = m.hit ? p : '0;
  end

endmodule

[hw/rtl/tile_gid_atlas_texcoord_top.sv]
// ----------------------------------------------------------------------------
// Tile gid to atlas texcoord: top level
// Channel   Dir  Handshake      Payload
// gid       in   valid/ready    raw_gid
// coords    out  valid/ready    hit, set_index, local_id, corner0..3 u/v
// cfg       in   cfg_we         cfg_index, cfg_data (write only)
//
// One item per cycle sustained while the coords sink is ready; stages from accept to result:
// tileset select, four divider stages (8 quotient bits each), multiply,
// corner/flip register which is also the output register.
// Synchronous reset clears stage valids and loads register defaults.
// Each stage advances when it is empty or the next one advances, so a
// stall holds items in place and bubbles are squeezed out.
// ----------------------------------------------------------------------------
`include "tile_gid_atlas_texcoord_top_defines.svh"

module tile_gid_atlas_texcoord_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tgat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tgat_pkg::WORD_W-1:0]        cfg_data,
  tgat_in_if.sink                            gid,
  tgat_out_if.source                         coords
);
  import tgat_pkg::*;

  // configuration
  logic [CNT_W-1:0]  set_count;
  logic [WORD_W-1:0] set_word [NUM_SETS];
  logic [CFG_IDX_W-1:0] word_off;

  assign word_off = cfg_index - REG_SET_WORD_0;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_count <= CNT_W'(1);
      for (int i = 0; i < NUM_SETS; i++) begin
        set_word[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_SET_COUNT) begin
        set_count <= cfg_data[CNT_W-1:0];
      end else if (cfg_index >= REG_SET_WORD_0 &&
                   word_off < CFG_IDX_W'(NUM_SETS)) begin
        set_word[word_off[SET_IDX_W-1:0]] <= cfg_data;
      end
    end
  end

  // stage A: tileset select and local id
  logic                 a_valid, a_en;
  div_item_t            a_item, a_next;
  logic [GID_W-1:0]     id;
  logic [CNT_W-1:0]     active;
  logic                 found;
  logic [SET_IDX_W-1:0] best;
  logic [FG_W-1:0]      best_fg;
  logic [FG_W-1:0]      fg;
  logic [WORD_W-1:0]    w;
  logic [COLS_W-1:0]    cols;

  always_comb begin
    id      = gid.raw_gid[GID_W-1:0];
    active  = (set_count > CNT_W'(NUM_SETS)) ? CNT_W'(NUM_SETS) : set_count;
    found   = 1'b0;
    best    = '0;
    best_fg = '0;
    fg      = '0;
    // later index wins on equal first gids
    for (int i = 0; i < NUM_SETS; i++) begin
      fg = set_word[i][FG_LSB +: FG_W];
      if (CNT_W'(i) < active && GID_W'(fg) <= id && (!found || fg >= best_fg)) begin
        found   = 1'b1;
        best    = SET_IDX_W'(i);
        best_fg = fg;
      end
    end
    w    = set_word[best];
    cols = w[COLS_LSB +: COLS_W];

    a_next = '0;
    if (gid.raw_gid != '0 && found && cols != '0) begin
      a_next.hit       = 1'b1;
      a_next.set_index = best;
      a_next.local_id  = id - GID_W'(best_fg);
      a_next.hf        = gid.raw_gid[HFLIP_BIT];
      a_next.vf        = gid.raw_gid[VFLIP_BIT];
      a_next.df        = gid.raw_gid[DFLIP_BIT];
      a_next.cols      = cols;
      a_next.tw        = w[TW_LSB +: BYTE_W];
      a_next.th        = w[TH_LSB +: BYTE_W];
      a_next.mg        = w[MG_LSB +: BYTE_W];
      a_next.sp        = w[SP_LSB +: BYTE_W];
      a_next.rem       = '0;
      a_next.dq        = DIV_W'(a_next.local_id);
    end
  end

  logic                 div_valid [DIV_STAGES];
  div_item_t            div_item  [DIV_STAGES];
  logic                 div_en    [DIV_STAGES];
  logic                 m_en;

  assign a_en      = !a_valid || div_en[0];
  assign gid.ready = a_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= gid.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_item <= a_next;
    end
  end

  // divider pipeline: quotient is the row, remainder the column
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic      up_valid;
    div_item_t up_item;
    logic      down_en;

    if (g == 0) begin : g_first
      assign up_valid = a_valid;
      assign up_item  = a_item;
    end else begin : g_rest
      assign up_valid = div_valid[g-1];
      assign up_item  = div_item[g-1];
    end

    if (g == DIV_STAGES - 1) begin : g_last
      assign down_en = m_en;
    end else begin : g_mid
      assign down_en = div_en[g+1];
    end

    tgat_div_stage u_div (
      .clk      (clk),
      .rst      (rst),
      .up_valid (up_valid),
      .up_item  (up_item),
      .down_en  (down_en),
      .valid    (div_valid[g]),
      .item     (div_item[g]),
      .en       (div_en[g])
    );
  end

  // stage M: column and row scaled by pitch
  logic              m_valid;
  mul_item_t         m_item, m_next;
  div_item_t         d_last;
  logic [BYTE_W:0]   pitch_u, pitch_v;
  logic              f_en;

  assign d_last = div_item[DIV_STAGES-1];

  always_comb begin
    pitch_u          = {1'b0, d_last.tw} + {1'b0, d_last.sp};
    pitch_v          = {1'b0, d_last.th} + {1'b0, d_last.sp};
    m_next.hit       = d_last.hit;
    m_next.set_index = d_last.set_index;
    m_next.local_id  = d_last.local_id;
    m_next.hf        = d_last.hf;
    m_next.vf        = d_last.vf;
    m_next.df        = d_last.df;
    m_next.tw        = d_last.tw;
    m_next.th        = d_last.th;
    m_next.mg        = d_last.mg;
    m_next.pu        = PU_W'(d_last.rem) * PU_W'(pitch_u);
    m_next.pv        = PV_W'(d_last.dq[GID_W-1:0]) * PV_W'(pitch_v);
  end

  assign m_en = !m_valid || f_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_en) begin
      m_valid <= div_valid[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (m_en) begin
      m_item <= m_next;
    end
  end

  // stage F: corners, flips, output register
  corners_t             c_next, f_c;
  logic                 f_valid;
  logic                 f_hit;
  logic [SET_IDX_W-1:0] f_set_index;
  logic [GID_W-1:0]     f_local_id;

  tgat_corner u_corner (
    .m (m_item),
    .c (c_next)
  );

  assign f_en = !f_valid || coords.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (f_en) begin
      f_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      f_hit       <= m_item.hit;
      f_set_index <= m_item.set_index;
      f_local_id  <= m_item.local_id;
      f_c         <= c_next;
    end
  end

  assign coords.valid     = f_valid;
  assign coords.hit       = f_hit;
  assign coords.set_index = f_set_index;
  assign coords.local_id  = f_local_id;
  assign coords.corner0_u = f_c.u[0];
  assign coords.corner0_v = f_c.v[0];
  assign coords.corner1_u = f_c.u[1];
  assign coords.corner1_v = f_c.v[1];
  assign coords.corner2_u = f_c.u[2];
  assign coords.corner2_v = f_c.v[2];
  assign coords.corner3_u = f_c.u[3];
  assign coords.corner3_v = f_c.v[3];

  // checks
  logic miss_clean, side_shared, zero_accept;

  assign miss_clean  = coords.set_index == '0 && coords.local_id == '0 &&
                       coords.corner0_u == '0 && coords.corner2_v == '0;
  assign side_shared = coords.corner0_u == coords.corner1_u ||
                       coords.corner0_v == coords.corner1_v;
  assign zero_accept = gid.valid && gid.ready && gid.raw_gid == '0;

  `TGAT_ASSERT_SAME(a_miss_zero, coords.valid && !coords.hit, miss_clean, "miss has nonzero fields")
  `TGAT_ASSERT_SAME(a_rect_adjacent, coords.valid && coords.hit, side_shared, "corners not adjacent")
  `TGAT_ASSERT_NEXT(a_zero_gid_miss, zero_accept, a_valid && !a_item.hit, "zero gid not a miss")

endmodule

[bench/tile_gid_atlas_texcoord_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tile gid to atlas texcoord: testbench
// Directed rows, then random tilesets and gids in twelve phases. Every result
// is checked against an in-bench lookup model (directed miss rows against zero),
// under random source and sink gaps in some phases and two long sink hold-offs.
// ----------------------------------------------------------------------------
module tile_gid_atlas_texcoord_top_tb;
  import tgat_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int HOLD_CYCLES     = 400;
  localparam int TAIL_CYCLES     = 16;
  localparam int DIR_ROWS        = 28;

  localparam logic [CFG_IDX_W-1:0] REG_PAST_END = CFG_IDX_W'(REG_SET_WORD_0 + NUM_SETS);
  localparam logic [CFG_IDX_W-1:0] REG_IDX_LAST = '1;

  typedef struct packed {
    logic                 hit;
    logic [SET_IDX_W-1:0] set_index;
    logic [GID_W-1:0]     local_id;
    coord_t [3:0]         u;
    coord_t [3:0]         v;
  } texcoord_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_ITEM, ROW_MISS} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [WORD_W-1:0]    value;
  } dir_row_t;

  logic clk;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  tgat_in_if  gid_if ();
  tgat_out_if coords_if ();

  tile_gid_atlas_texcoord_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gid       (gid_if),
    .coords    (coords_if)
  );

  // shadow of the tileset registers
  logic [CNT_W-1:0]  atlas_count;
  logic [WORD_W-1:0] atlas_word [NUM_SETS];

  texcoord_t coords_due_q [$];
  texcoord_t seen_coords;
  texcoord_t due_coords;
  int mismatches;
  int src_idle_pct;
  int sink_idle_pct;
  int hold_request;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] pack_set(input logic [FG_W-1:0] fg,
                                                 input logic [COLS_W-1:0] cols,
                                                 input logic [BYTE_W-1:0] tw,
                                                 input logic [BYTE_W-1:0] th,
                                                 input logic [BYTE_W-1:0] mg,
                                                 input logic [BYTE_W-1:0] sp);
    return {sp, mg, th, tw, cols, fg};
  endfunction

  function automatic texcoord_t predict_coords(input logic [RAW_W-1:0] raw);
    texcoord_t res;
    logic [GID_W-1:0] id;
    logic [FG_W-1:0] fg, best_fg;
    logic [WORD_W-1:0] w;
    logic [63:0] cols, tw, th, mg, sp, local_v, tu, tv, l, t, r, b;
    logic [63:0] bu [4];
    logic [63:0] bv [4];
    int ord [4];
    int active, best, tmp;
    logic found;
    res = '0;
    if (raw == '0) return res;
    id = raw[GID_W-1:0];
    active = (atlas_count > CNT_W'(NUM_SETS)) ? NUM_SETS : int'(atlas_count);
    found = 1'b0;
    best = 0;
    best_fg = '0;
    // ties go to the higher index
    for (int i = 0; i < active; i++) begin
      fg = atlas_word[i][FG_LSB +: FG_W];
      if (GID_W'(fg) <= id && (!found || fg >= best_fg)) begin
        found = 1'b1;
        best_fg = fg;
        best = i;
      end
    end
    if (!found) return res;
    w = atlas_word[best];
    cols = 64'(w[COLS_LSB +: COLS_W]);
    if (cols == 0) return res;
    tw = 64'(w[TW_LSB +: BYTE_W]);
    th = 64'(w[TH_LSB +: BYTE_W]);
    mg = 64'(w[MG_LSB +: BYTE_W]);
    sp = 64'(w[SP_LSB +: BYTE_W]);
    local_v = 64'(id) - 64'(best_fg);
    tu = local_v % cols;
    tv = local_v / cols;
    l = mg + tu * (tw + sp);
    t = mg + tv * (th + sp);
    r = l + tw;
    b = t + th;
    bu = '{l, r, r, l};
    bv = '{t, t, b, b};
    ord = '{0, 1, 2, 3};
    // corner permutation: horizontal, then vertical, then diagonal
    if (raw[HFLIP_BIT]) begin
      tmp = ord[0]; ord[0] = ord[1]; ord[1] = tmp;
      tmp = ord[3]; ord[3] = ord[2]; ord[2] = tmp;
    end
    if (raw[VFLIP_BIT]) begin
      tmp = ord[0]; ord[0] = ord[3]; ord[3] = tmp;
      tmp = ord[1]; ord[1] = ord[2]; ord[2] = tmp;
    end
    if (raw[DFLIP_BIT]) begin
      tmp = ord[1]; ord[1] = ord[3]; ord[3] = tmp;
    end
    res.hit = 1'b1;
    res.set_index = best[SET_IDX_W-1:0];
    res.local_id = local_v[GID_W-1:0];
    for (int j = 0; j < 4; j++) begin
      res.u[j] = bu[ord[j]][COORD_W-1:0];
      res.v[j] = bv[ord[j]][COORD_W-1:0];
    end
    return res;
  endfunction

  // mostly ids that land inside a configured tileset, some noise
  function automatic logic [RAW_W-1:0] pick_gid();
    logic [2:0] flips;
    logic [GID_W-1:0] id;
    logic [FG_W-1:0] fg;
    int k;
    flips = 3'($urandom_range(7, 0));
    k = $urandom_range(NUM_SETS - 1, 0);
    fg = atlas_word[k][FG_LSB +: FG_W];
    case ($urandom_range(19, 0))
      0: return '0;
      1: id = '0;
      2: return $urandom;
      3: id = GID_W'($urandom);
      4: id = GID_W'(fg - 1);
      5: id = {GID_W{1'b1}} - GID_W'($urandom_range(15, 0));
      6: id = GID_W'(fg + $urandom_range(1 << 20, 0));
      default: id = GID_W'(fg + $urandom_range(4095, 0));
    endcase
    return {flips, id};
  endfunction

  function automatic void flag_field(input string name, input logic [COORD_W-1:0] want_v,
                                     input logic [COORD_W-1:0] got_v);
    mismatches++;
    $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SET_COUNT) begin
      atlas_count = data[CNT_W-1:0];
    end else if (idx >= REG_SET_WORD_0 && idx < REG_PAST_END) begin
      atlas_word[SET_IDX_W'(idx - REG_SET_WORD_0)] = data;
    end
  endtask

  task automatic send_gid(input logic [RAW_W-1:0] raw, input texcoord_t want);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      gid_if.valid <= 1'b0;
      @(posedge clk);
    end
    gid_if.valid <= 1'b1;
    gid_if.raw_gid <= raw;
    @(posedge clk);
    while (!gid_if.ready) @(posedge clk);
    coords_due_q = {coords_due_q, want};
  endtask

  task automatic wait_drained();
    gid_if.valid <= 1'b0;
    do @(posedge clk); while (coords_due_q.size() != 0);
  endtask

  // sink side: random stalls plus an occasional long hold-off
  initial begin
    coords_if.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        coords_if.ready <= 1'b0;
      end else begin
        coords_if.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && coords_if.valid && coords_if.ready) begin
      seen_coords.hit = coords_if.hit;
      seen_coords.set_index = coords_if.set_index;
      seen_coords.local_id = coords_if.local_id;
      seen_coords.u[0] = coords_if.corner0_u;
      seen_coords.v[0] = coords_if.corner0_v;
      seen_coords.u[1] = coords_if.corner1_u;
      seen_coords.v[1] = coords_if.corner1_v;
      seen_coords.u[2] = coords_if.corner2_u;
      seen_coords.v[2] = coords_if.corner2_v;
      seen_coords.u[3] = coords_if.corner3_u;
      seen_coords.v[3] = coords_if.corner3_v;
      if (coords_due_q.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none got hit %0b set_index %0d local_id %0h",
                 $time, seen_coords.hit, seen_coords.set_index, seen_coords.local_id);
      end else begin
        due_coords = coords_due_q.pop_front();
        if (seen_coords.hit !== due_coords.hit)
          flag_field("hit", COORD_W'(due_coords.hit), COORD_W'(seen_coords.hit));
        if (seen_coords.set_index !== due_coords.set_index)
          flag_field("set_index", COORD_W'(due_coords.set_index),
                     COORD_W'(seen_coords.set_index));
        if (seen_coords.local_id !== due_coords.local_id)
          flag_field("local_id", COORD_W'(due_coords.local_id),
                     COORD_W'(seen_coords.local_id));
        for (int j = 0; j < 4; j++) begin
          if (seen_coords.u[j] !== due_coords.u[j])
            flag_field($sformatf("corner%0d_u", j), due_coords.u[j], seen_coords.u[j]);
          if (seen_coords.v[j] !== due_coords.v[j])
            flag_field($sformatf("corner%0d_v", j), due_coords.v[j], seen_coords.v[j]);
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tile_gid_atlas_texcoord_top: mismatch");
    $finish;
  end

  initial begin
    int ph, n;
    dir_row_t dir_rows [DIR_ROWS];
    logic [WORD_W-1:0] words [NUM_SETS];
    logic [WORD_W-1:0] count_word;
    logic [RAW_W-1:0] g;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gid_if.valid = 1'b0;
    gid_if.raw_gid = '0;
    mismatches = 0;
    hold_request = 0;
    src_idle_pct = 7;
    sink_idle_pct = 69;
    atlas_count = 1;
    for (int k = 0; k < NUM_SETS; k++) atlas_word[k] = '0;

    dir_rows = '{
      // reset tileset has zero columns: everything misses
      '{ROW_MISS,  REG_SET_COUNT,      62'h0000_0001},
      '{ROW_MISS,  REG_SET_COUNT,      62'hFFFF_FFFF},
      '{ROW_WRITE, REG_SET_WORD_0,     pack_set(20'd1, 10'd4, 8'd16, 8'd16, 8'd2, 8'd1)},
      '{ROW_ITEM,  REG_SET_COUNT,      62'h0000_0001},
      '{ROW_MISS,  REG_SET_COUNT,      62'h0000_0000},
      // flip bits only, id 0 is below every first gid
      '{ROW_MISS,  REG_SET_COUNT,      62'hE000_0000},
      '{ROW_ITEM,  REG_SET_COUNT,      62'h8000_0006},
      '{ROW_ITEM,  REG_SET_COUNT,      62'h4000_0007},
      '{ROW_ITEM,  REG_SET_COUNT,      62'h2000_0009},
      '{ROW_ITEM,  REG_SET_COUNT,      62'hE000_000B},
      '{ROW_WRITE, CFG_IDX_W'(REG_SET_WORD_0 + 1),
        pack_set(20'd0, 10'd0, 8'd8, 8'd8, 8'd0, 8'd0)},
      '{ROW_WRITE, REG_SET_COUNT,      62'h3FFF_FFFF_FFFF_FFFA},
      // matches the zero-column tileset
      '{ROW_MISS,  REG_SET_COUNT,      62'hE000_0000},
      '{ROW_ITEM,  REG_SET_COUNT,      62'h0000_0005},
      '{ROW_WRITE, CFG_IDX_W'(REG_SET_WORD_0 + 1), pack_set(20'd0, '1, '1, '1, '1, '1)},
      '{ROW_ITEM,  REG_SET_COUNT,      62'hE000_0000},
      '{ROW_WRITE, CFG_IDX_W'(REG_SET_WORD_0 + 2),
        pack_set(20'd1, 10'd3, 8'd5, 8'd7, 8'd9, 8'd11)},
      '{ROW_WRITE, CFG_IDX_W'(REG_SET_WORD_0 + 3), pack_set('1, 10'd1, '1, '1, '1, '1)},
      '{ROW_WRITE, REG_SET_COUNT,      62'h3FFF_FFFF_FFFF_FFFF},
      '{ROW_ITEM,  REG_SET_COUNT,      62'h0000_0001},
      '{ROW_ITEM,  REG_SET_COUNT,      62'h1FFF_FFFF},
      '{ROW_ITEM,  REG_SET_COUNT,      62'hFFFF_FFFF},
      '{ROW_WRITE, REG_PAST_END,       62'h3FFF_FFFF_FFFF_FFFF},
      '{ROW_WRITE, REG_IDX_LAST,       62'h2AAA_AAAA_AAAA_AAAA},
      '{ROW_ITEM,  REG_SET_COUNT,      62'h1FFF_FFFF},
      '{ROW_WRITE, REG_SET_COUNT,      62'h3FFF_FFFF_FFFF_FFF8},
      '{ROW_MISS,  REG_SET_COUNT,      62'h1FFF_FFFF},
      '{ROW_MISS,  REG_SET_COUNT,      62'hA000_0001}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int row = 0; row < DIR_ROWS; row++) begin
      case (dir_rows[row].kind)
        ROW_WRITE: begin
          wait_drained();
          write_reg(dir_rows[row].idx, dir_rows[row].value);
        end
        ROW_ITEM: send_gid(dir_rows[row].value[RAW_W-1:0],
                           predict_coords(dir_rows[row].value[RAW_W-1:0]));
        default: send_gid(dir_rows[row].value[RAW_W-1:0], '0);
      endcase
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph / 4)
        0: begin
          src_idle_pct = 7;
          sink_idle_pct = 69;
        end
        1: begin
          src_idle_pct = 69;
          sink_idle_pct = 7;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase

      count_word = WORD_W'({$urandom, $urandom});
      count_word[CNT_W-1:0] = ($urandom_range(9, 0) == 0) ? CNT_W'($urandom_range(7, 0))
                                                          : CNT_W'($urandom_range(NUM_SETS, 1));
      for (int k = 0; k < NUM_SETS; k++) begin
        words[k] = WORD_W'({$urandom, $urandom});
        case ($urandom_range(9, 0))
          0: words[k][COLS_LSB +: COLS_W] = '0;
          1: words[k][COLS_LSB +: COLS_W] = COLS_W'(1);
          2: words[k][COLS_LSB +: COLS_W] = '1;
          default: ;
        endcase
        case ($urandom_range(5, 0))
          0: words[k][FG_LSB +: FG_W] = '0;
          1: words[k][FG_LSB +: FG_W] = words[0][FG_LSB +: FG_W];
          2: words[k][FG_LSB +: FG_W] = FG_W'($urandom_range(15, 0));
          default: ;
        endcase
      end
      case (ph)
        0: begin
          count_word = '1;
          for (int k = 0; k < NUM_SETS; k++) words[k] = '1;
        end
        // one narrow column of the largest tiles: biggest coordinates
        4: begin
          count_word[CNT_W-1:0] = CNT_W'(1);
          words[0] = pack_set('0, 10'd1, '1, '1, '1, '1);
        end
        8: begin
          count_word[CNT_W-1:0] = CNT_W'(NUM_SETS);
          for (int k = 0; k < NUM_SETS; k++) words[k] = pack_set('0, '1, '0, '0, '0, '0);
        end
        default: ;
      endcase

      wait_drained();
      write_reg(REG_SET_COUNT, count_word);
      for (int k = 0; k < NUM_SETS; k++) write_reg(CFG_IDX_W'(REG_SET_WORD_0 + k), words[k]);
      if ($urandom_range(2, 0) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_IDX_LAST, REG_PAST_END)),
                  WORD_W'({$urandom, $urandom}));

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == 20 && (ph == 1 || ph == 9)) hold_request = HOLD_CYCLES;
        if (n == 70 && ph == 6) wait_drained();
        g = pick_gid();
        send_gid(g, predict_coords(g));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tile_gid_atlas_texcoord_top: match");
    end else begin
      $display("tile_gid_atlas_texcoord_top: mismatch");
    end
    $finish;
  end

endmodule
